// ----- hdl/dmx_pkg.sv -----
// Shared types and constants for the DMX512 slot receiver.
// No dependencies; used by dmx512_slot_receiver.
package dmx_pkg;

   localparam int SLOT_COUNT  = 512;
   localparam int STORE_DEPTH = 512;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int SLOT_W      = 10;
   localparam int BYTE_W      = 8;

   typedef enum logic [1:0] {
      CMD_BREAK = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_ERROR = 2'd2,
      CMD_READ  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_AWAIT   = 2'd1,
      MODE_RECEIVE = 2'd2,
      MODE_DONE    = 2'd3
   } mode_type;

   // Result fields carried alongside the slot store read.
   typedef struct packed {
      logic     hit;
      logic     addr_err;
      mode_type mode;
      logic     done;
   } stage_type;

endpackage

// ----- hdl/dmx512_slot_receiver.sv -----
// DMX512 slot receiver top level: command decode, frame state and slot store.
// Depends on dmx_pkg and dmx_ram.
//
// Takes one command word per clock and returns one result word for each,
// passed through one stage for the slot store read and then one result
// register. The slot store is a 512 x 8 RAM with a registered read port.
// It needs no clearing pass after reset: a fill mark records the highest slot
// ever stored, and a read above it returns zero, as a cleared entry would.
// Full throughput holds as long as the result side keeps taking words.
module dmx512_slot_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [9:0]  req_slot_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   output logic        rsp_address_error,
   output logic [1:0]  rsp_receiver_state,
   output logic        rsp_frame_complete
);

   localparam logic [dmx_pkg::SLOT_W-1:0] LAST_SLOT  = dmx_pkg::SLOT_W'(dmx_pkg::SLOT_COUNT);
   localparam logic [dmx_pkg::SLOT_W-1:0] STORE_TOP  = dmx_pkg::SLOT_W'(dmx_pkg::STORE_DEPTH);
   localparam logic [dmx_pkg::SLOT_W-1:0] SLOT_ONE   = dmx_pkg::SLOT_W'(1);

   dmx_pkg::mode_type                 mode_ff, mode_in;
   logic [dmx_pkg::SLOT_W-1:0]        next_slot_ff, next_slot_in;
   logic [dmx_pkg::SLOT_W-1:0]        fill_ff, fill_in;

   logic                              s1_valid_ff;
   dmx_pkg::stage_type                s1_ff, s1_in;

   logic                              rsp_valid_ff;
   logic [dmx_pkg::BYTE_W-1:0]        rsp_value_ff;
   dmx_pkg::stage_type                rsp_ff;

   logic                              accept;
   logic                              s1_move;
   logic                              wr_en;
   logic                              rd_en;
   logic [dmx_pkg::SLOT_W-1:0]        wr_slot_m1;
   logic [dmx_pkg::SLOT_W-1:0]        rd_slot_m1;
   logic [dmx_pkg::SLOT_W-1:0]        slot_inc;
   logic [dmx_pkg::BYTE_W-1:0]        ram_rd_data;
   logic                              addr_ok;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign wr_slot_m1 = next_slot_ff - SLOT_ONE;
   assign rd_slot_m1 = req_slot_address - SLOT_ONE;
   assign slot_inc   = next_slot_ff + SLOT_ONE;
   assign addr_ok    = (req_slot_address != '0) && (req_slot_address <= STORE_TOP);

   always_comb begin
      mode_in      = mode_ff;
      next_slot_in = next_slot_ff;
      fill_in      = fill_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      s1_in        = '{hit: 1'b0, addr_err: 1'b0, mode: dmx_pkg::MODE_IDLE, done: 1'b0};
      unique case (dmx_pkg::command_type'(req_command))
         dmx_pkg::CMD_BREAK: begin
            mode_in = dmx_pkg::MODE_AWAIT;
         end
         dmx_pkg::CMD_BYTE: begin
            if (mode_ff == dmx_pkg::MODE_AWAIT) begin
               if (req_data_byte == '0) begin
                  mode_in      = dmx_pkg::MODE_RECEIVE;
                  next_slot_in = SLOT_ONE;
               end else begin
                  mode_in = dmx_pkg::MODE_IDLE;
               end
            end else if (mode_ff == dmx_pkg::MODE_RECEIVE) begin
               if (next_slot_ff != '0 && next_slot_ff <= LAST_SLOT &&
                   next_slot_ff <= STORE_TOP) begin
                  wr_en        = 1'b1;
                  next_slot_in = slot_inc;
                  // slots are always filled upward from 1, so a high mark suffices
                  if (next_slot_ff > fill_ff) begin
                     fill_in = next_slot_ff;
                  end
                  if (slot_inc > LAST_SLOT || slot_inc == '0) begin
                     mode_in  = dmx_pkg::MODE_DONE;
                     s1_in.done = 1'b1;
                  end
               end else begin
                  mode_in = dmx_pkg::MODE_DONE;
               end
            end
         end
         dmx_pkg::CMD_ERROR: begin
            mode_in = dmx_pkg::MODE_IDLE;
         end
         dmx_pkg::CMD_READ: begin
            rd_en          = 1'b1;
            s1_in.addr_err = !addr_ok;
            s1_in.hit      = addr_ok && (req_slot_address <= fill_ff);
         end
      endcase
      s1_in.mode = mode_in;
   end

   dmx_ram #(
      .WIDTH (dmx_pkg::BYTE_W),
      .DEPTH (dmx_pkg::STORE_DEPTH)
   ) u_slot_store (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_slot_m1[dmx_pkg::STORE_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (accept && rd_en),
      .rd_addr (rd_slot_m1[dmx_pkg::STORE_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= dmx_pkg::MODE_IDLE;
         next_slot_ff <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            next_slot_ff <= next_slot_in;
            fill_ff      <= fill_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff       <= s1_ff;
         rsp_value_ff <= s1_ff.hit ? ram_rd_data : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_value_ff;
   assign rsp_address_error  = rsp_ff.addr_err;
   assign rsp_receiver_state = rsp_ff.mode;
   assign rsp_frame_complete = rsp_ff.done;

   a_err_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_error |-> rsp_read_value == '0)
      else $error("address error with nonzero read value");

   a_done_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_complete |-> rsp_receiver_state == dmx_pkg::MODE_DONE)
      else $error("frame complete outside frame done mode");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= STORE_TOP)
      else $error("fill mark beyond slot store");

   a_stage_excl: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_ff.hit && s1_ff.addr_err) && !(s1_ff.hit && s1_ff.done))
      else $error("conflicting stage flags");

endmodule

// ----- hdl/dmx_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb_dmx512_slot_receiver.sv -----
// Self-checking testbench for dmx512_slot_receiver: directed and random command words,
// per-word result prediction, random valid/ready idling in phases.
// Depends on dmx_pkg and the dmx512_slot_receiver RTL.
module tb_dmx512_slot_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      dmx_pkg::command_type cmd;
      logic [7:0]           data;
      logic [9:0]           addr;
      bit                   hold;   // wait for every pending result before offering this word
   } dmx_word_type;

   typedef struct packed {
      logic [7:0]        value;
      logic              addr_err;
      dmx_pkg::mode_type mode;
      logic              done;
   } slot_result_type;

   localparam int STIM_TARGET = 1450;
   localparam int PHASE_LEN   = 120;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = '0;
   logic [7:0] req_data_byte = '0;
   logic [9:0] req_slot_address = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_value;
   logic       rsp_address_error;
   logic [1:0] rsp_receiver_state;
   logic       rsp_frame_complete;

   dmx_word_type    stim_words[$];
   slot_result_type expected_results[$];
   dmx_word_type    on_wire;
   bit              hold_next = 1'b0;
   bit              all_returned = 1'b1;
   int              sent_count = 0;
   int              fail_count = 0;

   // predictor state
   dmx_pkg::mode_type rx_mode = dmx_pkg::MODE_IDLE;
   logic [9:0]        fill_slot = '0;
   logic [7:0]        slot_mem [dmx_pkg::SLOT_COUNT];

   dmx512_slot_receiver dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_data_byte      (req_data_byte),
      .req_slot_address   (req_slot_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_address_error  (rsp_address_error),
      .rsp_receiver_state (rsp_receiver_state),
      .rsp_frame_complete (rsp_frame_complete)
   );

   always #5 clock = ~clock;

   function automatic slot_result_type apply_command(dmx_word_type w);
      slot_result_type r;
      r = '0;
      case (w.cmd)
         dmx_pkg::CMD_BREAK: rx_mode = dmx_pkg::MODE_AWAIT;
         dmx_pkg::CMD_ERROR: rx_mode = dmx_pkg::MODE_IDLE;
         dmx_pkg::CMD_BYTE: begin
            if (rx_mode == dmx_pkg::MODE_AWAIT) begin
               if (w.data == 8'd0) begin
                  rx_mode   = dmx_pkg::MODE_RECEIVE;
                  fill_slot = 10'd1;
               end else begin
                  rx_mode = dmx_pkg::MODE_IDLE;
               end
            end else if (rx_mode == dmx_pkg::MODE_RECEIVE) begin
               if (fill_slot >= 1 && fill_slot <= dmx_pkg::SLOT_COUNT) begin
                  slot_mem[fill_slot - 1] = w.data;
                  fill_slot = fill_slot + 10'd1;
                  if (fill_slot > dmx_pkg::SLOT_COUNT || fill_slot == 10'd0) begin
                     rx_mode = dmx_pkg::MODE_DONE;
                     r.done  = 1'b1;
                  end
               end else begin
                  rx_mode = dmx_pkg::MODE_DONE;
               end
            end
         end
         dmx_pkg::CMD_READ: begin
            if (w.addr >= 1 && w.addr <= dmx_pkg::SLOT_COUNT)
               r.value = slot_mem[w.addr - 1];
            else
               r.addr_err = 1'b1;
         end
      endcase
      r.mode = rx_mode;
      return r;
   endfunction

   task automatic push_word(dmx_pkg::command_type c, logic [7:0] d, logic [9:0] a);
      stim_words.push_back('{cmd: c, data: d, addr: a, hold: hold_next});
      hold_next = 1'b0;
   endtask

   function automatic logic [9:0] pick_address();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 10'd0;
         1:       return 10'($urandom_range(dmx_pkg::SLOT_COUNT + 1, 1023));
         2:       return $urandom_range(0, 1) ? 10'd1 : 10'(dmx_pkg::SLOT_COUNT);
         3, 4:    return 10'($urandom_range(1, dmx_pkg::SLOT_COUNT));
         default: return 10'($urandom_range(1, 48));
      endcase
   endfunction

   task automatic push_read();
      push_word(dmx_pkg::CMD_READ, 8'($urandom), pick_address());
   endtask

   task automatic push_byte(logic [7:0] d);
      push_word(dmx_pkg::CMD_BYTE, d, 10'($urandom));
   endtask

   task automatic push_event(dmx_pkg::command_type c);
      push_word(c, 8'($urandom), 10'($urandom));
   endtask

   // sender
   always @(posedge clock) begin : drive
      int  idle_pct;
      int  phase;
      bit  go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_command(on_wire));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            phase    = (sent_count / PHASE_LEN) % 4;
            idle_pct = (phase == 1) ? 67 : (phase == 3) ? 11 : 0;
            go = stim_words.size() != 0 && $urandom_range(0, 99) >= idle_pct;
            if (go && stim_words[0].hold && !(all_returned && !(req_valid && req_ready)))
               go = 1'b0;
            if (go) begin
               on_wire = stim_words.pop_front();
               req_command      <= on_wire.cmd;
               req_data_byte    <= on_wire.data;
               req_slot_address <= on_wire.addr;
            end
            req_valid <= go;
         end
      end
   end

   always @(negedge clock) all_returned = (expected_results.size() == 0);

   // receiver and checker
   always @(posedge clock) begin : check
      slot_result_type want;
      slot_result_type got;
      int              phase;
      int              stall_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.value    = rsp_read_value;
            got.addr_err = rsp_address_error;
            got.mode     = dmx_pkg::mode_type'(rsp_receiver_state);
            got.done     = rsp_frame_complete;
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display({"%0t: result word with nothing expected:",
                            " value=%h err=%b state=%0d done=%b"},
                           $realtime, got.value, got.addr_err, got.mode, got.done);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value || got.addr_err !== want.addr_err ||
                   got.mode !== want.mode || got.done !== want.done) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch: exp value=%h err=%b state=%0d done=%b",
                               " / got value=%h err=%b state=%0d done=%b"},
                              $realtime, want.value, want.addr_err, want.mode, want.done,
                              got.value, got.addr_err, got.mode, got.done);
                  fail_count++;
               end
            end
         end
         phase     = (sent_count / PHASE_LEN) % 4;
         stall_pct = (phase == 2) ? 67 : (phase == 3) ? 11 : 0;
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin : stimulus
      int kind;
      int len;
      int full_frames;
      full_frames = 0;
      foreach (slot_mem[i]) slot_mem[i] = 8'd0;

      // cleared store, range limits of the read address
      push_word(dmx_pkg::CMD_READ, 8'hFF, 10'd1);
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'(dmx_pkg::SLOT_COUNT));
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'd0);
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'(dmx_pkg::SLOT_COUNT + 1));
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'h3FF);
      push_word(dmx_pkg::CMD_BYTE, 8'hFF, 10'h3FF);     // ignored while idle
      // non-zero start code drops back to idle
      push_word(dmx_pkg::CMD_BREAK, 8'h00, 10'h000);
      push_word(dmx_pkg::CMD_BYTE, 8'h5A, 10'h000);
      push_word(dmx_pkg::CMD_BYTE, 8'h00, 10'h000);
      // break while awaiting, then a real frame
      push_word(dmx_pkg::CMD_BREAK, 8'hFF, 10'h3FF);
      push_word(dmx_pkg::CMD_BREAK, 8'h00, 10'h000);
      push_word(dmx_pkg::CMD_BYTE, 8'h00, 10'h3FF);
      push_word(dmx_pkg::CMD_BYTE, 8'hFF, 10'h000);
      push_word(dmx_pkg::CMD_BYTE, 8'h00, 10'h000);
      push_word(dmx_pkg::CMD_BYTE, 8'hA5, 10'h000);
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'd2);      // read during capture
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'd3);
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'd4);
      push_word(dmx_pkg::CMD_ERROR, 8'hFF, 10'h3FF);   // line error mid-frame, store kept
      push_word(dmx_pkg::CMD_BYTE, 8'h11, 10'h000);
      push_word(dmx_pkg::CMD_READ, 8'hFF, 10'd1);
      push_word(dmx_pkg::CMD_BREAK, 8'h00, 10'h000);
      push_word(dmx_pkg::CMD_ERROR, 8'h00, 10'h000);
      push_word(dmx_pkg::CMD_READ, 8'h00, 10'd3);

      hold_next = 1'b1;
      while (stim_words.size() < STIM_TARGET) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            repeat (8) push_word(dmx_pkg::command_type'($urandom_range(0, 3)), 8'($urandom),
                                 10'($urandom));
         end else if (kind == 1) begin
            push_event(dmx_pkg::CMD_BREAK);
            push_byte(8'($urandom_range(1, 255)));
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            push_read();
         end else begin
            push_event(dmx_pkg::CMD_BREAK);
            push_byte(8'd0);
            if (full_frames == 0 || (full_frames == 1 && stim_words.size() > 750)) begin
               len = dmx_pkg::SLOT_COUNT;
               full_frames++;
            end else begin
               len = $urandom_range(1, 48);
            end
            repeat (len) begin
               push_byte(8'($urandom));
               if ($urandom_range(0, 4) == 0) push_read();
            end
            if (len == dmx_pkg::SLOT_COUNT) begin
               // bytes after the last slot are dropped
               repeat (3) push_byte(8'($urandom));
               push_word(dmx_pkg::CMD_READ, 8'($urandom), 10'(dmx_pkg::SLOT_COUNT));
               push_word(dmx_pkg::CMD_READ, 8'($urandom), 10'd1);
               push_read();
               hold_next = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
               push_event(dmx_pkg::CMD_ERROR);
               if ($urandom_range(0, 1)) push_byte(8'($urandom));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (stim_words.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("tb_dmx512_slot_receiver: done, clean");
      else
         $display("tb_dmx512_slot_receiver: done, errors");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_dmx512_slot_receiver: done, errors");
      $finish;
   end

endmodule
